@@ rtl/core/tsl_pkg.sv @@
package tsl_pkg;

  // Default width of the payload byte position
  localparam int POSITION_BITS_DEF = 16;

  // Record and handshake header codes
  localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0] REC_MAJOR       = 8'h03;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] NAME_TYPE_HOST  = 8'h00;

  // Layout constants
  localparam int MIN_PAYLOAD  = 43;
  localparam int MIN_HS_LEN   = 38;
  localparam int SESSID_POS   = 34;
  localparam int SNI_MIN_EXT  = 5;
  localparam int HDR_BYTES    = 9;
  localparam int EXT_HDR      = 4;
  localparam int SNI_EXT_TYPE = 0;

  // Header byte positions
  localparam int POS_TYPE     = 0;
  localparam int POS_MAJOR    = 1;
  localparam int POS_HS_TYPE  = 5;
  localparam int POS_LEN_HI   = 6;
  localparam int POS_LEN_LO   = 8;

  // Output beat width: found, offset, length, padded to whole bytes
  localparam int OUT_BITS  = 1 + 16 + 16;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_W     = OUT_BYTES * 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [15:0] length;
  } result_t;

endpackage

@@ rtl/core/tsl_in_stage.sv @@
module tsl_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] data_byte
  input  logic          s_tlast,   // last_byte
  input  logic          consume,
  output logic          valid,
  output tsl_pkg::beat_t beat
);
  import tsl_pkg::*;

  // Take a new beat when empty or when the held one moves on
  assign s_tready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.data <= s_tdata;
      beat.last <= s_tlast;
    end
  end

endmodule

@@ rtl/core/tsl_parser.sv @@
module tsl_parser #(
  parameter int POSITION_BITS = tsl_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  tsl_pkg::beat_t   beat,
  output tsl_pkg::result_t result
);
  import tsl_pkg::*;

  // Handshake-relative arithmetic width: room for a position plus a 16-bit length
  localparam int HW = ((POSITION_BITS > 24) ? POSITION_BITS : 24) + 2;

  typedef enum logic [10:0] {
    PH_HDR        = 11'b000_0000_0001,
    PH_SESSID     = 11'b000_0000_0010,
    PH_CIPHERS    = 11'b000_0000_0100,
    PH_COMP       = 11'b000_0000_1000,
    PH_EXTLEN     = 11'b000_0001_0000,
    PH_ETYPE      = 11'b000_0010_0000,
    PH_ELEN_SNI   = 11'b000_0100_0000,
    PH_ELEN_OTHER = 11'b000_1000_0000,
    PH_NAME_TYPE  = 11'b001_0000_0000,
    PH_NAME_LEN   = 11'b010_0000_0000,
    PH_DONE       = 11'b100_0000_0000
  } phase_t;

  logic [POSITION_BITS-1:0] pos, pos_next;
  phase_t                   phase, phase_next;
  logic [23:0]              hs_len, hs_len_next;
  logic [7:0]               acc, acc_next;
  logic [HW-1:0]            nx, nx_next;
  logic [HW-1:0]            ext_end, ext_end_next;
  logic [HW-1:0]            rec_end, rec_end_next;
  logic                     header_ok, header_ok_next;
  logic                     cand_valid, cand_valid_next;
  logic [15:0]              cand_off, cand_off_next;
  logic [15:0]              cand_len, cand_len_next;

  logic [HW-1:0] h, hl, n_byte, n_word, acc_word, plen, goto_start;
  logic [23:0]   len_shift;
  logic [31:0]   pos_plus1;
  logic          fail, do_goto, ok_parse, found;

  always_comb begin
    h         = HW'(pos) - HW'(HDR_BYTES);
    hl        = HW'(hs_len);
    acc_word  = HW'({acc, beat.data});
    n_byte    = h + HW'(1) + HW'(beat.data);
    n_word    = h + HW'(1) + acc_word;
    len_shift = {hs_len[15:0], beat.data};
    pos_plus1 = 32'(pos) + 32'd1;
    plen      = HW'(pos) + HW'(1);

    pos_next        = pos;
    phase_next      = phase;
    hs_len_next     = hs_len;
    acc_next        = acc;
    nx_next         = nx;
    ext_end_next    = ext_end;
    rec_end_next    = rec_end;
    cand_valid_next = cand_valid;
    cand_off_next   = cand_off;
    cand_len_next   = cand_len;
    fail            = 1'b0;
    do_goto         = 1'b0;
    goto_start      = '0;

    case (phase)
      PH_HDR: begin
        if ((pos == POSITION_BITS'(POS_TYPE) && beat.data != REC_HANDSHAKE) ||
            (pos == POSITION_BITS'(POS_MAJOR) && beat.data != REC_MAJOR) ||
            (pos == POSITION_BITS'(POS_HS_TYPE) && beat.data != HS_CLIENT_HELLO)) begin
          fail = 1'b1;
        end else begin
          // Shift in the 24-bit handshake length
          if (pos >= POSITION_BITS'(POS_LEN_HI) && pos <= POSITION_BITS'(POS_LEN_LO)) begin
            hs_len_next = len_shift;
          end
          if (pos == POSITION_BITS'(POS_LEN_LO)) begin
            if (len_shift < 24'(MIN_HS_LEN)) begin
              fail = 1'b1;
            end else begin
              nx_next    = HW'(SESSID_POS);
              phase_next = PH_SESSID;
            end
          end
        end
      end
      PH_SESSID: begin
        if (h == nx) begin
          if (n_byte + HW'(2) > hl) begin
            fail = 1'b1;
          end else begin
            nx_next    = n_byte;
            phase_next = PH_CIPHERS;
          end
        end
      end
      PH_CIPHERS: begin
        if (h == nx) begin
          acc_next = beat.data;
        end else if (h == nx + HW'(1)) begin
          if (n_word + HW'(1) > hl) begin
            fail = 1'b1;
          end else begin
            nx_next    = n_word;
            phase_next = PH_COMP;
          end
        end
      end
      PH_COMP: begin
        if (h == nx) begin
          if (n_byte + HW'(2) > hl) begin
            fail = 1'b1;
          end else begin
            nx_next    = n_byte;
            phase_next = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN: begin
        if (h == nx) begin
          acc_next = beat.data;
        end else if (h == nx + HW'(1)) begin
          if (n_word > hl) begin
            fail = 1'b1;
          end else begin
            ext_end_next = n_word;
            do_goto      = 1'b1;
            goto_start   = h + HW'(1);
          end
        end
      end
      PH_ETYPE: begin
        if (h == nx) begin
          acc_next = beat.data;
        end else if (h == nx + HW'(1)) begin
          phase_next = (acc_word == HW'(SNI_EXT_TYPE)) ? PH_ELEN_SNI : PH_ELEN_OTHER;
        end
      end
      PH_ELEN_SNI, PH_ELEN_OTHER: begin
        if (h == nx + HW'(2)) begin
          acc_next = beat.data;
        end else if (h == nx + HW'(3)) begin
          if (n_word > ext_end) begin
            // Broken extension ends the walk
            phase_next = PH_DONE;
          end else begin
            rec_end_next = n_word;
            if (phase == PH_ELEN_SNI && acc_word >= HW'(SNI_MIN_EXT)) begin
              // Skip the list length
              nx_next    = h + HW'(3);
              phase_next = PH_NAME_TYPE;
            end else begin
              do_goto    = 1'b1;
              goto_start = n_word;
            end
          end
        end
      end
      PH_NAME_TYPE: begin
        if (h == nx) begin
          if (beat.data != NAME_TYPE_HOST) begin
            do_goto    = 1'b1;
            goto_start = rec_end;
          end else begin
            nx_next    = h + HW'(1);
            phase_next = PH_NAME_LEN;
          end
        end
      end
      PH_NAME_LEN: begin
        if (h == nx) begin
          acc_next = beat.data;
        end else if (h == nx + HW'(1)) begin
          if (acc_word != '0 && n_word <= rec_end) begin
            cand_valid_next = 1'b1;
            cand_off_next   = pos_plus1[15:0];
            cand_len_next   = {acc, beat.data};
            phase_next      = PH_DONE;
          end else begin
            do_goto    = 1'b1;
            goto_start = rec_end;
          end
        end
      end
      default: begin
      end
    endcase

    // Move to the next extension header, or stop past the block
    if (do_goto) begin
      nx_next    = goto_start;
      phase_next = (goto_start + HW'(EXT_HDR) > ext_end_next) ? PH_DONE : PH_ETYPE;
    end

    ok_parse = header_ok && !fail;
    if (fail) begin
      phase_next = PH_DONE;
    end

    // Advance the position, saturating on an over-long payload
    header_ok_next = ok_parse;
    if (pos == '1) begin
      header_ok_next = 1'b0;
    end else begin
      pos_next = pos + POSITION_BITS'(1);
    end

    // Final verdict on the marked byte
    found = ok_parse && cand_valid_next && (plen >= HW'(MIN_PAYLOAD)) &&
            (HW'(HDR_BYTES) + HW'(hs_len_next) <= plen);
    result.found  = found;
    result.offset = found ? cand_off_next : 16'd0;
    result.length = found ? cand_len_next : 16'd0;
  end

  // Re-arm on reset and after each marked byte
  always_ff @(posedge clk) begin
    if (rst || (adv && beat.last)) begin
      pos        <= '0;
      phase      <= PH_HDR;
      hs_len     <= '0;
      acc        <= '0;
      nx         <= '0;
      ext_end    <= '0;
      rec_end    <= '0;
      header_ok  <= 1'b1;
      cand_valid <= 1'b0;
      cand_off   <= '0;
      cand_len   <= '0;
    end else if (adv) begin
      pos        <= pos_next;
      phase      <= phase_next;
      hs_len     <= hs_len_next;
      acc        <= acc_next;
      nx         <= nx_next;
      ext_end    <= ext_end_next;
      rec_end    <= rec_end_next;
      header_ok  <= header_ok_next;
      cand_valid <= cand_valid_next;
      cand_off   <= cand_off_next;
      cand_len   <= cand_len_next;
    end
  end

endmodule

@@ rtl/core/tsl_out_stage.sv @@
module tsl_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  tsl_pkg::result_t            result,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tsl_pkg::OUT_W-1:0]   m_tdata   // [0] sni_found, [16:1] sni_offset,
                                                // [32:17] sni_length, rest zero
);
  import tsl_pkg::*;

  // Room for a new result when empty or when the held one leaves
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Pack the result beat
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_W'({result.length, result.offset, result.found});
    end
  end

endmodule

@@ rtl/core/tls_sni_locator.sv @@
// A marked last byte passes the input register, then the result register, to m_tvalid.
// Throughput: one payload byte per cycle while no last byte waits for a busy result slot;
// the two registers decouple the sides; non-last bytes keep flowing while a result waits.
// Reset: rst is synchronous, active high; it empties both registers and re-arms the parser.
// The parser also re-arms by itself after every last byte.
module tls_sni_locator #(
  parameter int POSITION_BITS = tsl_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] data_byte
  input  logic                      s_tlast,   // last_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [tsl_pkg::OUT_W-1:0] m_tdata    // [0] sni_found, [16:1] sni_offset,
                                               // [32:17] sni_length, rest zero
);
  import tsl_pkg::*;

  logic    in_valid;
  beat_t   beat;
  logic    consume;
  logic    out_free;
  result_t result;

  tsl_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .consume  (consume),
    .valid    (in_valid),
    .beat     (beat)
  );

  // Parse a byte unless it is the last one and the result slot is busy
  assign consume = in_valid && (!beat.last || out_free);

  tsl_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .adv    (consume),
    .beat   (beat),
    .result (result)
  );

  tsl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && beat.last),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ rtl/core/tsl_checker.sv @@
module tsl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [7:0]                s_tdata,
  input logic                      s_tlast,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [tsl_pkg::OUT_W-1:0] m_tdata
);
  import tsl_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Not found carries zero offset and length
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
    else $error("nonzero fields on a not-found result");

  // A found name is never empty
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[32:17] != 16'd0)
    else $error("found result with zero length");

  // Reset empties the result side
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind tls_sni_locator tsl_checker u_tsl_checker (.*);

@@ dv/sni_result_checker.sv @@
module sni_result_checker #(
  parameter int POSITION_BITS = tsl_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] data_byte
  input  logic                      s_tlast,   // last_byte
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [tsl_pkg::OUT_W-1:0] m_tdata,   // [0] sni_found, [16:1] sni_offset,
                                               // [32:17] sni_length, rest zero
  output int                        errors,
  output int                        pending
);
  import tsl_pkg::*;

  localparam int unsigned POS_LIMIT = (1 << POSITION_BITS) - 1;

  typedef enum logic [3:0] {
    WALK_HDR, WALK_SESSID, WALK_CIPHERS, WALK_COMP, WALK_EXTLEN, WALK_ETYPE,
    WALK_ELEN_SNI, WALK_ELEN_OTHER, WALK_NAME_TYPE, WALK_NAME_LEN, WALK_DONE
  } walk_e;

  // Shadow parser state; positions past the header are handshake-relative
  walk_e       walk_st;
  int unsigned byte_pos;
  int unsigned hs_len;
  int unsigned acc;
  int unsigned next_pos;
  int unsigned ext_end;
  int unsigned rec_end;
  bit          hdr_good;
  bit          name_seen;
  logic [15:0] name_off;
  logic [15:0] name_len;

  result_t sni_expect_q[$];

  initial errors = 0;

  task automatic log_miss(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic rearm();
    walk_st   = WALK_HDR;
    byte_pos  = 0;
    hs_len    = 0;
    acc       = 0;
    next_pos  = 0;
    ext_end   = 0;
    rec_end   = 0;
    hdr_good  = 1'b1;
    name_seen = 1'b0;
    name_off  = '0;
    name_len  = '0;
  endtask

  task automatic abort_walk();
    hdr_good = 1'b0;
    walk_st  = WALK_DONE;
  endtask

  // Jump to the extension header at start, or stop if none fits
  task automatic enter_ext(input int unsigned start);
    next_pos = start;
    walk_st  = (start + EXT_HDR > ext_end) ? WALK_DONE : WALK_ETYPE;
  endtask

  task automatic walk_byte(input int unsigned pos, input int unsigned b);
    int unsigned h;
    int unsigned nx;
    int unsigned n;
    int unsigned len;
    h  = pos - HDR_BYTES;
    nx = next_pos;
    case (walk_st)
      WALK_HDR: begin
        if ((pos == POS_TYPE && b != REC_HANDSHAKE) || (pos == POS_MAJOR && b != REC_MAJOR) ||
            (pos == POS_HS_TYPE && b != HS_CLIENT_HELLO)) begin
          abort_walk();
          return;
        end
        if (pos >= POS_LEN_HI && pos <= POS_LEN_LO)
          hs_len = ((hs_len << 8) | b) & 32'hFF_FFFF;
        if (pos == POS_LEN_LO) begin
          if (hs_len < MIN_HS_LEN) begin
            abort_walk();
            return;
          end
          next_pos = SESSID_POS;
          walk_st  = WALK_SESSID;
        end
      end
      WALK_SESSID: begin
        if (h == nx) begin
          n = h + 1 + b;
          if (n + 2 > hs_len) begin
            abort_walk();
            return;
          end
          next_pos = n;
          walk_st  = WALK_CIPHERS;
        end
      end
      WALK_CIPHERS: begin
        if (h == nx) begin
          acc = b;
        end else if (h == nx + 1) begin
          n = h + 1 + ((acc << 8) | b);
          if (n + 1 > hs_len) begin
            abort_walk();
            return;
          end
          next_pos = n;
          walk_st  = WALK_COMP;
        end
      end
      WALK_COMP: begin
        if (h == nx) begin
          n = h + 1 + b;
          if (n + 2 > hs_len) begin
            abort_walk();
            return;
          end
          next_pos = n;
          walk_st  = WALK_EXTLEN;
        end
      end
      WALK_EXTLEN: begin
        if (h == nx) begin
          acc = b;
        end else if (h == nx + 1) begin
          n = h + 1 + ((acc << 8) | b);
          if (n > hs_len) begin
            abort_walk();
            return;
          end
          ext_end = n;
          enter_ext(h + 1);
        end
      end
      WALK_ETYPE: begin
        if (h == nx) begin
          acc = b;
        end else if (h == nx + 1) begin
          walk_st = (((acc << 8) | b) == SNI_EXT_TYPE) ? WALK_ELEN_SNI : WALK_ELEN_OTHER;
        end
      end
      WALK_ELEN_SNI, WALK_ELEN_OTHER: begin
        if (h == nx + 2) begin
          acc = b;
        end else if (h == nx + 3) begin
          len = (acc << 8) | b;
          n   = h + 1 + len;
          // A record past the extension block ends the walk, header stays good
          if (n > ext_end) begin
            walk_st = WALK_DONE;
            return;
          end
          rec_end = n;
          if (walk_st == WALK_ELEN_SNI && len >= SNI_MIN_EXT) begin
            next_pos = h + 3;
            walk_st  = WALK_NAME_TYPE;
          end else begin
            enter_ext(n);
          end
        end
      end
      WALK_NAME_TYPE: begin
        if (h == nx) begin
          if (b != NAME_TYPE_HOST) begin
            enter_ext(rec_end);
          end else begin
            next_pos = h + 1;
            walk_st  = WALK_NAME_LEN;
          end
        end
      end
      WALK_NAME_LEN: begin
        if (h == nx) begin
          acc = b;
        end else if (h == nx + 1) begin
          len = (acc << 8) | b;
          if (len > 0 && h + 1 + len <= rec_end) begin
            name_seen = 1'b1;
            name_off  = 16'(pos + 1);
            name_len  = 16'(len);
            walk_st   = WALK_DONE;
          end else begin
            enter_ext(rec_end);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Advance the shadow parser by one payload byte; queue a result on the last one
  task automatic predict_sni(input logic [7:0] d, input logic l);
    int unsigned pos;
    int unsigned plen;
    result_t     res;
    pos = byte_pos;
    walk_byte(pos, d);
    if (l) begin
      plen       = pos + 1;
      res.found  = hdr_good && name_seen && plen >= MIN_PAYLOAD && HDR_BYTES + hs_len <= plen;
      res.offset = res.found ? name_off : 16'd0;
      res.length = res.found ? name_len : 16'd0;
      sni_expect_q.push_back(res);
      rearm();
    end else if (pos >= POS_LIMIT) begin
      hdr_good = 1'b0;
    end else begin
      byte_pos = pos + 1;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (sni_expect_q.size() == 0) begin
      log_miss($sformatf("result beat %h with no result expected", m_tdata));
      return;
    end
    want = sni_expect_q.pop_front();
    if (m_tdata[0] !== want.found)
      log_miss($sformatf("sni_found got %b want %b", m_tdata[0], want.found));
    if (m_tdata[16:1] !== want.offset)
      log_miss($sformatf("sni_offset got %0d want %0d", m_tdata[16:1], want.offset));
    if (m_tdata[32:17] !== want.length)
      log_miss($sformatf("sni_length got %0d want %0d", m_tdata[32:17], want.length));
  endtask

  // Watch both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      rearm();
    end else begin
      if (s_tvalid && s_tready)
        predict_sni(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        check_result();
    end
    pending = sni_expect_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import tsl_pkg::*;

  localparam int ITEMS        = 1100;
  localparam int MIN_PAYLOADS = 48;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    FLAW_NONE, FLAW_REC_TYPE, FLAW_MAJOR, FLAW_HS_TYPE, FLAW_HS_SHORT, FLAW_HS_BIG,
    FLAW_TRUNC, FLAW_SESSID, FLAW_CIPHERS, FLAW_COMP, FLAW_EXTLEN, FLAW_EXT_OVER,
    FLAW_TAIL, FLAW_COUNT
  } flaw_e;

  typedef enum int {
    SNI_GOOD, SNI_BAD_TYPE, SNI_ZERO_NAME, SNI_LONG_NAME, SNI_SHORT_EXT, SNI_ABSENT
  } sni_kind_e;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;
  int                 chk_errors;
  int                 chk_pending;

  // Payload under construction and its extension block
  logic [7:0] pkt[$];
  logic [7:0] exts[$];
  int         sid_at;
  int         cs_at;
  int         comp_at;
  int         extlen_at;
  int         ext_base;
  int         last_elen_at;

  int beats_sent = 0;
  int payloads   = 0;
  int src_calm   = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  always #10 clk = ~clk;

  tls_sni_locator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sni_result_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (chk_errors),
    .pending  (chk_pending)
  );

  // Offer one beat, hold it until taken, then maybe go idle for a burst
  task automatic send_beat(input logic [7:0] d, input logic l);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (quiet) begin
      src_calm = 0;
    end else if (src_calm > 0) begin
      src_calm--;
    end else if ($urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end else if ($urandom_range(0, 99) == 0) begin
      src_calm = $urandom_range(30, 150);
    end
  endtask

  task automatic send_pkt();
    int i;
    for (i = 0; i < pkt.size(); i++)
      send_beat(pkt[i], i == pkt.size() - 1);
    payloads++;
  endtask

  task automatic put_hs_len(input int unsigned v);
    pkt[POS_LEN_HI]     = v[23:16];
    pkt[POS_LEN_HI + 1] = v[15:8];
    pkt[POS_LEN_LO]     = v[7:0];
  endtask

  task automatic build_noise(input int len);
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom));
    // Sometimes look like a record header to get past the first checks
    if ($urandom_range(0, 1)) begin
      pkt[0] = REC_HANDSHAKE;
      if (pkt.size() > 1) pkt[1] = REC_MAJOR;
    end
  endtask

  task automatic add_other();
    int          len;
    logic [15:0] etype;
    case ($urandom_range(0, 2))
      0:       etype = {8'h00, 8'($urandom_range(1, 255))};
      1:       etype = {8'($urandom_range(1, 255)), 8'h00};
      default: etype = 16'($urandom_range(1, 65535));
    endcase
    len = $urandom_range(0, 10);
    exts.push_back(etype[15:8]);
    exts.push_back(etype[7:0]);
    last_elen_at = exts.size();
    exts.push_back(8'h00);
    exts.push_back(8'(len));
    repeat (len) exts.push_back(8'($urandom));
  endtask

  // Append a server_name extension, well formed or broken in one way
  task automatic add_sni(input sni_kind_e kind, input int nlen);
    int          ext_len;
    int          body_bytes;
    int          slack;
    logic [15:0] nl_field;
    logic [15:0] list_len;
    logic [7:0]  ntype;
    slack      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    ntype      = NAME_TYPE_HOST;
    nl_field   = 16'(nlen);
    body_bytes = nlen;
    case (kind)
      SNI_BAD_TYPE:  ntype = 8'($urandom_range(1, 255));
      SNI_ZERO_NAME: begin
        nl_field   = 16'd0;
        body_bytes = 0;
      end
      SNI_LONG_NAME: begin
        nl_field = 16'(nlen + $urandom_range(1, 3));
        slack    = 0;
      end
      default: ;
    endcase
    exts.push_back(8'h00);
    exts.push_back(8'h00);
    last_elen_at = exts.size();
    if (kind == SNI_SHORT_EXT) begin
      ext_len = $urandom_range(0, SNI_MIN_EXT - 1);
      exts.push_back(8'h00);
      exts.push_back(8'(ext_len));
      repeat (ext_len) exts.push_back(8'($urandom));
    end else begin
      ext_len  = 5 + body_bytes + slack;
      list_len = $urandom_range(0, 1) ? 16'(ext_len - 2) : 16'($urandom);
      exts.push_back(8'(ext_len >> 8));
      exts.push_back(8'(ext_len));
      exts.push_back(list_len[15:8]);
      exts.push_back(list_len[7:0]);
      exts.push_back(ntype);
      exts.push_back(nl_field[15:8]);
      exts.push_back(nl_field[7:0]);
      repeat (body_bytes + slack) exts.push_back(8'($urandom_range(8'h61, 8'h7a)));
    end
  endtask

  // Build a ClientHello payload into pkt, then apply at most one flaw
  task automatic build_hello(input flaw_e flaw, input sni_kind_e kind, input int nlen,
                             input bit bare);
    logic [7:0]  body[$];
    int          n;
    int          i;
    int          cut;
    int unsigned hs;
    logic [15:0] v;
    pkt.delete();
    exts.delete();
    last_elen_at = -1;

    if (!bare) repeat ($urandom_range(0, 2)) add_other();
    if (kind != SNI_ABSENT) begin
      // An invalid server name entry ahead of the good one must be walked past
      if (!bare && kind == SNI_GOOD && $urandom_range(0, 3) == 0)
        add_sni(sni_kind_e'($urandom_range(SNI_BAD_TYPE, SNI_SHORT_EXT)), $urandom_range(1, 12));
      add_sni(kind, nlen);
    end
    if (!bare) repeat ($urandom_range(0, 2)) add_other();

    // Version and random
    body.push_back(REC_MAJOR);
    body.push_back(8'h03);
    repeat (32) body.push_back(8'($urandom));
    // Session id
    n = bare ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 4));
    sid_at = body.size();
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    // Cipher suites
    n = bare ? 0 : 2 * $urandom_range(0, 6);
    cs_at = body.size();
    body.push_back(8'(n >> 8));
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    // Compression methods
    n = bare ? 0 : $urandom_range(0, 2);
    comp_at = body.size();
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    // Extensions
    extlen_at = body.size();
    body.push_back(8'(exts.size() >> 8));
    body.push_back(8'(exts.size()));
    ext_base = body.size();
    foreach (exts[i]) body.push_back(exts[i]);

    hs = body.size();
    pkt.push_back(REC_HANDSHAKE);
    pkt.push_back(REC_MAJOR);
    pkt.push_back(8'($urandom_range(0, 4)));
    pkt.push_back(8'((hs + 4) >> 8));
    pkt.push_back(8'(hs + 4));
    pkt.push_back(HS_CLIENT_HELLO);
    repeat (3) pkt.push_back(8'h00);
    put_hs_len(hs);
    foreach (body[i]) pkt.push_back(body[i]);

    case (flaw)
      FLAW_REC_TYPE: pkt[POS_TYPE]    = REC_HANDSHAKE ^ 8'($urandom_range(1, 255));
      FLAW_MAJOR:    pkt[POS_MAJOR]   = REC_MAJOR ^ 8'($urandom_range(1, 255));
      FLAW_HS_TYPE:  pkt[POS_HS_TYPE] = HS_CLIENT_HELLO ^ 8'($urandom_range(1, 255));
      FLAW_HS_SHORT: put_hs_len($urandom_range(0, 1) ? MIN_HS_LEN : $urandom_range(0, MIN_HS_LEN));
      FLAW_HS_BIG:   put_hs_len($urandom_range(0, 1) ? hs + $urandom_range(1, 300)
                                                     : $urandom_range(0, 24'hFF_FFFF));
      FLAW_TRUNC: begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
      FLAW_SESSID:   pkt[HDR_BYTES + sid_at] = 8'($urandom);
      FLAW_CIPHERS:  pkt[HDR_BYTES + cs_at + $urandom_range(0, 1)] = 8'($urandom);
      FLAW_COMP:     pkt[HDR_BYTES + comp_at] = 8'($urandom);
      FLAW_EXTLEN: begin
        v = $urandom_range(0, 1) ? 16'(exts.size() + $urandom_range(1, 40)) : 16'($urandom);
        pkt[HDR_BYTES + extlen_at]     = v[15:8];
        pkt[HDR_BYTES + extlen_at + 1] = v[7:0];
      end
      FLAW_EXT_OVER: begin
        // Stretch the last extension so it runs past the block
        if (last_elen_at >= 0) begin
          i = HDR_BYTES + ext_base + last_elen_at;
          v = {pkt[i], pkt[i + 1]} + 16'($urandom_range(1, 20));
          pkt[i]     = v[15:8];
          pkt[i + 1] = v[7:0];
        end
      end
      FLAW_TAIL:     repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold on request
  initial begin : sink_ctl
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        m_tready <= 1'b1;
        calm_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(40, 200);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int f;
    int k;
    int r;
    int start_beats;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-byte payloads at both data extremes
    for (k = 0; k < 2; k++) begin
      pkt.delete();
      pkt.push_back(k ? 8'hFF : 8'h00);
      send_pkt();
    end
    // Smallest hello, without and with a name; a long name
    build_hello(FLAW_NONE, SNI_ABSENT, 1, 1'b1);
    send_pkt();
    build_hello(FLAW_NONE, SNI_GOOD, 1, 1'b1);
    send_pkt();
    build_hello(FLAW_NONE, SNI_GOOD, 300, 1'b0);
    send_pkt();
    // Each broken server name layout
    for (k = SNI_BAD_TYPE; k <= SNI_ABSENT; k++) begin
      build_hello(FLAW_NONE, sni_kind_e'(k), 6, 1'b0);
      send_pkt();
    end
    // Each header or length flaw around a good name
    for (f = FLAW_REC_TYPE; f < FLAW_COUNT; f++) begin
      build_hello(flaw_e'(f), SNI_GOOD, 8, 1'b0);
      send_pkt();
    end
    // Payload one byte short of the minimum
    build_hello(FLAW_NONE, SNI_GOOD, 4, 1'b1);
    while (pkt.size() >= MIN_PAYLOAD) void'(pkt.pop_back());
    send_pkt();

    // Hold the result side while tiny payloads pile up behind it
    hold_req = 1'b1;
    repeat (40) begin
      build_noise($urandom_range(1, 3));
      send_pkt();
    end
    while (hold_req) @(negedge clk);

    // Position limit: exactly at the limit, then one byte over
    quiet = 1'b1;
    for (k = 0; k < 2; k++) begin
      build_hello(FLAW_NONE, SNI_GOOD, 65000, 1'b1);
      while (pkt.size() < (1 << POSITION_BITS_DEF) + k) pkt.push_back(8'($urandom));
      send_pkt();
    end
    quiet = 1'b0;

    // Random mix, mostly well-formed hellos with random content
    start_beats = beats_sent;
    while (beats_sent - start_beats < ITEMS || payloads < MIN_PAYLOADS + 60) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        build_noise($urandom_range(1, 60));
      end else if (r < 65) begin
        build_hello($urandom_range(0, 4) == 0 ? FLAW_TAIL : FLAW_NONE,
                    $urandom_range(0, 4) == 0 ? sni_kind_e'($urandom_range(SNI_GOOD, SNI_ABSENT))
                                              : SNI_GOOD,
                    $urandom_range(0, 7) == 0 ? $urandom_range(21, 400) : $urandom_range(1, 20),
                    $urandom_range(0, 9) == 0);
      end else begin
        build_hello(flaw_e'($urandom_range(FLAW_REC_TYPE, FLAW_COUNT - 1)),
                    sni_kind_e'($urandom_range(SNI_GOOD, SNI_ABSENT)),
                    $urandom_range(1, 24), $urandom_range(0, 9) == 0);
      end
      send_pkt();
    end

    // Final stretch at full rate on both sides
    quiet = 1'b1;
    repeat (8) begin
      build_hello(FLAW_NONE, SNI_GOOD, $urandom_range(1, 20), 1'b0);
      send_pkt();
    end
    s_tvalid <= 1'b0;

    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
